>>> rtl/core/xsf_pkg.sv
// Package for the x86 status flags unit: transaction structs, item kinds,
// operand size codes and condition code names. No dependencies.

package xsf_pkg;

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_SUB   = 3'd1;
  localparam logic [2:0] KIND_LOGIC = 3'd2;
  localparam logic [2:0] KIND_COND  = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;
  localparam logic [2:0] KIND_WRITE = 3'd5;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // Condition code pairs; the low code bit inverts the test.
  localparam logic [2:0] CC_O  = 3'd0;
  localparam logic [2:0] CC_C  = 3'd1;
  localparam logic [2:0] CC_Z  = 3'd2;
  localparam logic [2:0] CC_BE = 3'd3;
  localparam logic [2:0] CC_S  = 3'd4;
  localparam logic [2:0] CC_P  = 3'd5;
  localparam logic [2:0] CC_L  = 3'd6;
  localparam logic [2:0] CC_LE = 3'd7;

  // Always-one bits of the packed flags word (bits 1 and 9).
  localparam logic [63:0] FIXED_ONES = 64'h0000_0000_0000_0202;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  size_sel;
    logic [63:0] result_value;
    logic [63:0] left_value;
    logic [63:0] right_value;
    logic        keep_carry;
    logic        equal_zero;
    logic [3:0]  condition_code;
    logic [63:0] flags_in;
  } xsf_in_t;

  typedef struct packed {
    logic        carry_flag;
    logic        parity_flag;
    logic        adjust_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
    logic        direction_flag;
    logic        condition_true;
    logic [63:0] flags_word;
  } xsf_out_t;

  typedef struct packed {
    logic cf;
    logic pf;
    logic af;
    logic zf;
    logic sf;
    logic of;
    logic df;
  } xsf_flags_t;

endpackage

>>> rtl/core/x86_status_flags_unit.sv
// x86 status flags unit: flag state, flag update, condition test, flags word
// pack/unpack. Depends on xsf_pkg.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o   in_data_i  (xsf_in_t)
//   out      out  out_valid_o/out_stall_i out_data_o (xsf_out_t)
//
// One transaction per cycle unless stalled; result registered on acceptance.
// Flags update and result capture happen at the same edge, from the input port
// through one level of compare/select logic into the result register.
// Reset clears all flags and empties the result register.
// in_stall_o is high only while a result is held and out_stall_i is high.

module x86_status_flags_unit
  import xsf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  xsf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output xsf_out_t out_data_o
);

  xsf_flags_t flags_q, flags_d;
  xsf_out_t   out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  logic [63:0] mask;
  logic [63:0] res_m, lhs_m, rhs_m, fin_m;
  logic        res_msb, lhs_msb, rhs_msb, xor_msb;
  logic        slt, cond_raw, cond_out;
  logic [63:0] packed_word;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (in_data_i.size_sel)
      SIZE_8:  mask = 64'h0000_0000_0000_00ff;
      SIZE_16: mask = 64'h0000_0000_0000_ffff;
      SIZE_32: mask = 64'h0000_0000_ffff_ffff;
      default: mask = '1;
    endcase
  end

  assign res_m = in_data_i.result_value & mask;
  assign lhs_m = in_data_i.left_value & mask;
  assign rhs_m = in_data_i.right_value & mask;
  assign fin_m = in_data_i.flags_in & mask;

  // add overflow term: ~(l ^ r) & (res ^ l)
  always_comb begin
    logic [63:0] ovf_vec;
    ovf_vec = ~(lhs_m ^ rhs_m) & (res_m ^ lhs_m);
    case (in_data_i.size_sel)
      SIZE_8: begin
        res_msb = res_m[7];  lhs_msb = lhs_m[7];  rhs_msb = rhs_m[7];  xor_msb = ovf_vec[7];
      end
      SIZE_16: begin
        res_msb = res_m[15]; lhs_msb = lhs_m[15]; rhs_msb = rhs_m[15]; xor_msb = ovf_vec[15];
      end
      SIZE_32: begin
        res_msb = res_m[31]; lhs_msb = lhs_m[31]; rhs_msb = rhs_m[31]; xor_msb = ovf_vec[31];
      end
      default: begin
        res_msb = res_m[63]; lhs_msb = lhs_m[63]; rhs_msb = rhs_m[63]; xor_msb = ovf_vec[63];
      end
    endcase
  end

  assign slt = (lhs_msb != rhs_msb) ? lhs_msb : (lhs_m < rhs_m);

  always_comb begin
    case (in_data_i.condition_code[3:1])
      CC_O:    cond_raw = flags_q.of;
      CC_C:    cond_raw = flags_q.cf;
      CC_Z:    cond_raw = flags_q.zf;
      CC_BE:   cond_raw = flags_q.cf | flags_q.zf;
      CC_S:    cond_raw = flags_q.sf;
      CC_P:    cond_raw = flags_q.pf;
      CC_L:    cond_raw = flags_q.sf ^ flags_q.of;
      default: cond_raw = flags_q.zf | (flags_q.sf ^ flags_q.of);
    endcase
  end
  assign cond_out = cond_raw ^ in_data_i.condition_code[0];

  always_comb begin
    packed_word     = FIXED_ONES;
    packed_word[0]  = flags_q.cf;
    packed_word[2]  = flags_q.pf;
    packed_word[4]  = flags_q.af;
    packed_word[6]  = flags_q.zf;
    packed_word[7]  = flags_q.sf;
    packed_word[10] = flags_q.df;
    packed_word[11] = flags_q.of;
  end

  always_comb begin
    flags_d = flags_q;
    out_d   = out_q;
    if (accept) begin
      out_d.condition_true = 1'b0;
      out_d.flags_word     = '0;
      case (in_data_i.kind)
        KIND_ADD, KIND_SUB: begin
          flags_d.sf = res_msb;
          flags_d.pf = ~^res_m[7:0];
          flags_d.af = lhs_m[4] ^ rhs_m[4] ^ res_m[4];
          if (in_data_i.kind == KIND_ADD) begin
            flags_d.zf = (res_m == '0);
            if (!in_data_i.keep_carry) flags_d.cf = (res_m < lhs_m);
            flags_d.of = xor_msb;
          end else begin
            flags_d.zf = in_data_i.equal_zero ? (lhs_m == rhs_m) : (res_m == '0);
            if (!in_data_i.keep_carry) flags_d.cf = (lhs_m < rhs_m);
            flags_d.of = res_msb ^ slt;
          end
        end
        KIND_LOGIC: begin
          flags_d.sf = res_msb;
          flags_d.pf = ~^res_m[7:0];
          flags_d.af = 1'b0;
        end
        KIND_COND: begin
          out_d.condition_true = cond_out;
        end
        KIND_READ: begin
          out_d.flags_word = packed_word & mask;
        end
        KIND_WRITE: begin
          flags_d.cf = fin_m[0];
          flags_d.pf = fin_m[2];
          flags_d.af = fin_m[4];
          flags_d.zf = fin_m[6];
          flags_d.sf = fin_m[7];
          if (in_data_i.size_sel != SIZE_8) begin
            flags_d.df = fin_m[10];
            flags_d.of = fin_m[11];
          end
        end
        default: ;
      endcase
      out_d.carry_flag     = flags_d.cf;
      out_d.parity_flag    = flags_d.pf;
      out_d.adjust_flag    = flags_d.af;
      out_d.zero_flag      = flags_d.zf;
      out_d.sign_flag      = flags_d.sf;
      out_d.overflow_flag  = flags_d.of;
      out_d.direction_flag = flags_d.df;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a held result");

  a_cond_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.condition_true) |-> (out_data_o.flags_word == '0))
    else $error("condition result carries a flags word");

  a_word_fixed_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.flags_word != '0)) |-> out_data_o.flags_word[1])
    else $error("flags word lacks fixed bit 1");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.carry_flag == flags_q.cf &&
                     out_data_o.overflow_flag == flags_q.of &&
                     out_data_o.direction_flag == flags_q.df))
    else $error("held result differs from flag state");

  a_flags_stable_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(flags_q))
    else $error("flags changed without a transaction");

endmodule

>>> tb/sv/tb_x86_status_flags_unit.sv
// Self-checking testbench for x86_status_flags_unit: queue-fed driver, monitor with
// scoreboard against an in-bench flag predictor, random bursts and stalls.
// Depends on xsf_pkg and the x86_status_flags_unit RTL.

module tb_x86_status_flags_unit;
  import xsf_pkg::*;

  localparam logic [2:0] KIND_RSVD_LO = 3'd6;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_e;

  typedef struct {
    xsf_in_t item;
    bit      wait_drain;
  } pending_item_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  xsf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  xsf_out_t out_data;

  pending_item_t pend_q[$];
  xsf_out_t      flags_exp_q[$];
  xsf_flags_t    flag_state = '0;

  int unsigned error_count = 0;
  int unsigned report_count = 0;
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_run = 0;
  int unsigned idle_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic        stall_hold = 1'b0;
  logic        take_next;
  logic        offer;
  pending_item_t head;
  xsf_out_t    exp_res;

  x86_status_flags_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    case (sz)
      SIZE_8:  return 64'h0000_0000_0000_00FF;
      SIZE_16: return 64'h0000_0000_0000_FFFF;
      SIZE_32: return 64'h0000_0000_FFFF_FFFF;
      default: return '1;
    endcase
  endfunction

  function automatic logic top_bit(input logic [63:0] v, input logic [1:0] sz);
    case (sz)
      SIZE_8:  return v[7];
      SIZE_16: return v[15];
      SIZE_32: return v[31];
      default: return v[63];
    endcase
  endfunction

  function automatic logic cond_holds(input logic [3:0] code);
    logic r;
    case (code[3:1])
      CC_O:    r = flag_state.of;
      CC_C:    r = flag_state.cf;
      CC_Z:    r = flag_state.zf;
      CC_BE:   r = flag_state.cf | flag_state.zf;
      CC_S:    r = flag_state.sf;
      CC_P:    r = flag_state.pf;
      CC_L:    r = flag_state.sf ^ flag_state.of;
      default: r = flag_state.zf | (flag_state.sf ^ flag_state.of);
    endcase
    return r ^ code[0];
  endfunction

  // Applies one transaction to the flag state, returns the expected result.
  function automatic xsf_out_t predict_flags(input xsf_in_t t);
    logic [63:0] m, res, lhs, rhs, fin, word;
    logic        sf, slt;
    xsf_out_t    o;
    m   = size_mask(t.size_sel);
    res = t.result_value & m;
    lhs = t.left_value & m;
    rhs = t.right_value & m;
    fin = t.flags_in & m;
    o   = '0;
    case (t.kind)
      KIND_ADD, KIND_SUB: begin
        sf = top_bit(res, t.size_sel);
        flag_state.sf = sf;
        flag_state.pf = ~^res[7:0];
        flag_state.af = lhs[4] ^ rhs[4] ^ res[4];
        if (t.kind == KIND_ADD) begin
          flag_state.zf = (res == 64'd0);
          if (!t.keep_carry) flag_state.cf = (res < lhs);
          flag_state.of = top_bit(~(lhs ^ rhs) & (res ^ lhs), t.size_sel);
        end else begin
          if (top_bit(lhs, t.size_sel) != top_bit(rhs, t.size_sel)) begin
            slt = top_bit(lhs, t.size_sel);
          end else begin
            slt = (lhs < rhs);
          end
          flag_state.zf = t.equal_zero ? (lhs == rhs) : (res == 64'd0);
          if (!t.keep_carry) flag_state.cf = (lhs < rhs);
          flag_state.of = sf ^ slt;
        end
      end
      KIND_LOGIC: begin
        flag_state.sf = top_bit(res, t.size_sel);
        flag_state.pf = ~^res[7:0];
        flag_state.af = 1'b0;
      end
      KIND_COND: begin
        o.condition_true = cond_holds(t.condition_code);
      end
      KIND_READ: begin
        word = FIXED_ONES;
        word[0]  = flag_state.cf;
        word[2]  = flag_state.pf;
        word[4]  = flag_state.af;
        word[6]  = flag_state.zf;
        word[7]  = flag_state.sf;
        word[10] = flag_state.df;
        word[11] = flag_state.of;
        o.flags_word = word & m;
      end
      KIND_WRITE: begin
        flag_state.cf = fin[0];
        flag_state.pf = fin[2];
        flag_state.af = fin[4];
        flag_state.zf = fin[6];
        flag_state.sf = fin[7];
        // DF and OF sit above bit 7, out of reach of a byte-wide write
        if (t.size_sel != SIZE_8) begin
          flag_state.df = fin[10];
          flag_state.of = fin[11];
        end
      end
      default: ;
    endcase
    o.carry_flag     = flag_state.cf;
    o.parity_flag    = flag_state.pf;
    o.adjust_flag    = flag_state.af;
    o.zero_flag      = flag_state.zf;
    o.sign_flag      = flag_state.sf;
    o.overflow_flag  = flag_state.of;
    o.direction_flag = flag_state.df;
    return o;
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
      3:       return 64'($urandom_range(0, 255));
      4:       return 64'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic xsf_in_t base_item(input logic [2:0] k, input logic [1:0] sz);
    xsf_in_t t;
    t.kind           = k;
    t.size_sel       = sz;
    t.result_value   = pick_operand();
    t.left_value     = pick_operand();
    t.right_value    = pick_operand();
    t.keep_carry     = 1'b0;
    t.equal_zero     = 1'b0;
    t.condition_code = 4'($urandom_range(0, 15));
    t.flags_in       = {$urandom, $urandom};
    return t;
  endfunction

  task automatic queue_item(input xsf_in_t t, input bit drain);
    pending_item_t p;
    p.item       = t;
    p.wait_drain = drain;
    pend_q.push_back(p);
  endtask

  // Driver: bursts with random gaps, optional drain before marked transactions.
  always @(posedge clk) begin
    if (rst_n) begin
      take_next = !in_valid || !in_stall;
      if (in_valid && !in_stall) flags_exp_q.push_back(predict_flags(in_data));
      if (take_next) begin
        offer = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pend_q.size() != 0 &&
                     !(pend_q[0].wait_drain && flags_exp_q.size() != 0)) begin
          offer = 1'b1;
          head = pend_q.pop_front();
          in_data <= head.item;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // Monitor: scoreboard check and receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (flags_exp_q.size() == 0) begin
          error_count++;
          if (report_count < REPORT_LIMIT) begin
            report_count++;
            $display("unexpected result: word=%h", out_data.flags_word);
          end
        end else begin
          exp_res = flags_exp_q.pop_front();
          if (exp_res.carry_flag !== out_data.carry_flag ||
              exp_res.parity_flag !== out_data.parity_flag ||
              exp_res.adjust_flag !== out_data.adjust_flag ||
              exp_res.zero_flag !== out_data.zero_flag ||
              exp_res.sign_flag !== out_data.sign_flag ||
              exp_res.overflow_flag !== out_data.overflow_flag ||
              exp_res.direction_flag !== out_data.direction_flag ||
              exp_res.condition_true !== out_data.condition_true ||
              exp_res.flags_word !== out_data.flags_word) begin
            error_count++;
            if (report_count < REPORT_LIMIT) begin
              report_count++;
              $display("mismatch exp: cf=%b pf=%b af=%b zf=%b sf=%b of=%b df=%b cc=%b word=%h",
                       exp_res.carry_flag, exp_res.parity_flag, exp_res.adjust_flag,
                       exp_res.zero_flag, exp_res.sign_flag, exp_res.overflow_flag,
                       exp_res.direction_flag, exp_res.condition_true, exp_res.flags_word);
              $display("         got: cf=%b pf=%b af=%b zf=%b sf=%b of=%b df=%b cc=%b word=%h",
                       out_data.carry_flag, out_data.parity_flag, out_data.adjust_flag,
                       out_data.zero_flag, out_data.sign_flag, out_data.overflow_flag,
                       out_data.direction_flag, out_data.condition_true, out_data.flags_word);
            end
          end
        end
      end
      stall_phase++;
      if (stall_phase == 97) begin
        stall_phase = 0;
        stall_mode = stall_mode_e'($urandom_range(0, 2));
      end
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_run == 0) begin
            stall_run = $urandom_range(1, 16);
            stall_hold = ~stall_hold;
          end
          stall_run--;
          out_stall <= stall_hold;
        end
      endcase
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stim
    xsf_in_t     t;
    logic [2:0]  k;
    int unsigned r;
    int unsigned n;
    int          cc;

    // directed
    t = base_item(KIND_WRITE, SIZE_64);
    t.flags_in = '1;
    queue_item(t, 1'b0);
    queue_item(base_item(KIND_READ, SIZE_8), 1'b0);
    t = base_item(KIND_WRITE, SIZE_8);
    t.flags_in = 64'hFFFF_FFFF_FFFF_FF00;
    queue_item(t, 1'b0);
    queue_item(base_item(KIND_READ, SIZE_16), 1'b0);
    t = base_item(KIND_ADD, SIZE_8);
    t.left_value = 64'hFF;
    t.right_value = 64'h01;
    t.result_value = 64'h100;
    queue_item(t, 1'b0);
    t = base_item(KIND_ADD, SIZE_64);
    t.left_value = 64'h7FFF_FFFF_FFFF_FFFF;
    t.right_value = 64'h1;
    t.result_value = 64'h8000_0000_0000_0000;
    t.keep_carry = 1'b1;
    queue_item(t, 1'b0);
    t = base_item(KIND_SUB, SIZE_32);
    t.left_value = 64'hFFFF_FFFF_8000_0000;
    t.right_value = 64'h1;
    t.result_value = t.left_value - t.right_value;
    t.equal_zero = 1'b1;
    queue_item(t, 1'b0);
    t = base_item(KIND_SUB, SIZE_16);
    t.left_value = 64'hABCD_1234;
    t.right_value = 64'h0000_1234;
    t.result_value = 64'h5A5A;
    t.equal_zero = 1'b1;
    queue_item(t, 1'b0);
    t = base_item(KIND_SUB, SIZE_64);
    t.left_value = '0;
    t.right_value = '1;
    t.result_value = 64'h1;
    queue_item(t, 1'b0);
    t = base_item(KIND_LOGIC, SIZE_64);
    t.result_value = 64'h8000_0000_0000_0000;
    queue_item(t, 1'b0);
    queue_item(base_item(KIND_RSVD_LO, SIZE_32), 1'b0);
    for (cc = 0; cc < 16; cc++) begin
      t = base_item(KIND_COND, SIZE_64);
      t.condition_code = 4'(cc);
      queue_item(t, 1'b0);
    end

    // random, mostly consistent arithmetic
    n = 0;
    while (n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 24) k = KIND_ADD;
      else if (r < 48) k = KIND_SUB;
      else if (r < 60) k = KIND_LOGIC;
      else if (r < 78) k = KIND_COND;
      else if (r < 87) k = KIND_READ;
      else if (r < 97) k = KIND_WRITE;
      else k = r[0] ? KIND_RSVD_HI : KIND_RSVD_LO;
      t = base_item(k, 2'($urandom_range(0, 3)));
      t.keep_carry = 1'($urandom_range(0, 1));
      t.equal_zero = 1'($urandom_range(0, 1));
      if (k == KIND_ADD && $urandom_range(0, 3) != 0) begin
        t.result_value = t.left_value + t.right_value;
      end
      if (k == KIND_SUB) begin
        if ($urandom_range(0, 4) == 0) t.right_value = t.left_value;
        if ($urandom_range(0, 3) != 0) t.result_value = t.left_value - t.right_value;
      end
      queue_item(t, (n % 100) == 0);
      if (k != KIND_RSVD_LO && k != KIND_RSVD_HI) n++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // sampled mid-cycle so that edge updates from the driver have settled
    @(negedge clk);
    while (pend_q.size() != 0 || in_valid || flags_exp_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/xsf_pkg.sv
rtl/core/x86_status_flags_unit.sv
tb/sv/tb_x86_status_flags_unit.sv
